// ===== hdl/ssp_pkg.sv =====
package ssp_pkg;

   localparam int VERTICES_DEF    = 64;
   localparam int MAX_EDGES_DEF   = 256;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int VTX_BITS  = 6;
   localparam int DIST_BITS = 24;
   localparam int WIN_BITS  = 16;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_RUN = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REV,
      S_EDGE,
      S_RDA,
      S_RDB,
      S_UPD,
      S_NEG,
      S_OUT_RD,
      S_OUT_LD
   } state_type;

endpackage

// ===== hdl/ssp_req_if.sv =====
interface ssp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 opcode;
   logic [ssp_pkg::VTX_BITS-1:0]         from_vertex;
   logic [ssp_pkg::VTX_BITS-1:0]         to_vertex;
   logic signed [ssp_pkg::WIN_BITS-1:0]  edge_weight;
   logic                                 two_way;
   logic [ssp_pkg::VTX_BITS-1:0]         source_vertex;

   modport source (output valid, opcode, from_vertex, to_vertex, edge_weight, two_way,
                   source_vertex, input ready);
   modport sink (input valid, opcode, from_vertex, to_vertex, edge_weight, two_way,
                 source_vertex, output ready);
endinterface

// ===== hdl/ssp_rsp_if.sv =====
interface ssp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [ssp_pkg::VTX_BITS-1:0]          vertex_index;
   logic signed [ssp_pkg::DIST_BITS-1:0]  distance;
   logic                                  reachable;
   logic [ssp_pkg::VTX_BITS-1:0]          parent_vertex;
   logic                                  negative_cycle;
   logic                                  edges_dropped;
   logic                                  last;

   modport source (output valid, vertex_index, distance, reachable, parent_vertex,
                   negative_cycle, edges_dropped, last, input ready);
   modport sink (input valid, vertex_index, distance, reachable, parent_vertex,
                 negative_cycle, edges_dropped, last, output ready);
endinterface

// ===== hdl/single_source_shortest_paths.sv =====
// channel  dir  beat carries
// req_bus  in   opcode, from_vertex, to_vertex, edge_weight, two_way, source_vertex
// rsp_bus  out  vertex_index, distance, reachable, parent_vertex, negative_cycle,
//               edges_dropped, last
// edge load: a two-way edge also stores its reverse entry in S_REV (edge store has one write port)
// run: each pass steps through the stored edges as a serial read-modify-write on the distance
//   memory: read edge, read from-vertex, read to-vertex, write; at most VERTICES passes
// results: each vertex given is read in S_OUT_RD and loaded in S_OUT_LD, each unseen vertex below
//   the last one given is skipped in S_OUT_RD (all are skipped when none is seen); S_OUT_LD waits while rsp_bus stalls
// reset clears control, flags and valid bits at once; no clearing pass over memories
// a run is taken while the last result of the previous run still waits in the output register
module single_source_shortest_paths #(
   parameter int VERTICES    = ssp_pkg::VERTICES_DEF,
   parameter int MAX_EDGES   = ssp_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   ssp_req_if.sink    req_bus,
   ssp_rsp_if.source  rsp_bus
);

   localparam int VB  = ssp_pkg::VTX_BITS;
   localparam int DB  = ssp_pkg::DIST_BITS;
   localparam int VAW = $clog2(VERTICES);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int CW  = $clog2(MAX_EDGES + 1);
   localparam int PW  = $clog2(VERTICES + 1);
   localparam int EW  = 2 * VB + WEIGHT_BITS;
   localparam int DW  = DB + VB;
   localparam logic signed [32:0] WMAX = 33'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
   localparam logic signed [32:0] WMIN = -WMAX - 33'sd1;
   localparam logic signed [33:0] DMAX = 34'sd8388607;
   localparam logic signed [33:0] DMIN = -34'sd8388608;

   ssp_pkg::state_type state_ff, state_in;

   logic [CW-1:0]              count_ff;
   logic                       overflow_ff;
   logic [VERTICES-1:0]        seen_ff;
   logic [VERTICES-1:0]        reach_ff;
   logic [CW-1:0]              k_ff;
   logic [PW-1:0]              pass_ff;
   logic                       any_ff;
   logic [VB-1:0]              src_ff;
   logic                       src_ok_ff;
   logic [VB-1:0]              rev_a_ff, rev_b_ff;
   logic [WEIGHT_BITS-1:0]     rev_w_ff;
   logic [VB-1:0]              ea_ff, eb_ff;
   logic signed [WEIGHT_BITS-1:0] ew_ff;
   logic signed [DB-1:0]       da_ff;
   logic [VAW-1:0]             v_ff;

   logic                       rsp_valid_ff;
   logic [VB-1:0]              o_vertex_ff, o_parent_ff;
   logic signed [DB-1:0]       o_dist_ff;
   logic                       o_reach_ff, o_neg_ff, o_drop_ff, o_last_ff;

   logic                       e_we;
   logic [EAW-1:0]             e_waddr;
   logic [EW-1:0]              e_wdata, e_rdata;
   logic                       d_we;
   logic [VAW-1:0]             d_waddr, d_raddr;
   logic [DW-1:0]              d_wdata, d_rdata;

   logic                       req_beat, out_free, room, in_range, src_in_range;
   logic signed [32:0]         w_ext, w_sat;
   logic signed [33:0]         sum, cand_w;
   logic signed [DB-1:0]       cand, db_dist;
   logic                       reach_a, reach_b, relax;
   logic [VERTICES-1:0]        seen_all, ahead;
   logic                       more;
   logic                       load_vtx, load_neg;

   ssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock (clock),
      .we    (e_we),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .raddr (k_ff[EAW-1:0]),
      .rdata (e_rdata)
   );

   ssp_ram #(.WIDTH(DW), .DEPTH(VERTICES)) u_dist_ram (
      .clock (clock),
      .we    (d_we),
      .waddr (d_waddr),
      .wdata (d_wdata),
      .raddr (d_raddr),
      .rdata (d_rdata)
   );

   assign req_bus.ready = (state_ff == ssp_pkg::S_IDLE);
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign room          = count_ff < CW'(MAX_EDGES);
   assign in_range      = ({1'b0, req_bus.from_vertex} < (VB + 1)'(VERTICES)) &&
                          ({1'b0, req_bus.to_vertex} < (VB + 1)'(VERTICES));
   assign src_in_range  = {1'b0, req_bus.source_vertex} < (VB + 1)'(VERTICES);

   assign w_ext = 33'(req_bus.edge_weight);
   assign w_sat = (w_ext > WMAX) ? WMAX : ((w_ext < WMIN) ? WMIN : w_ext);

   // saturating relaxation of the current edge
   assign sum     = 34'(da_ff) + 34'(ew_ff);
   assign cand_w  = (sum > DMAX) ? DMAX : ((sum < DMIN) ? DMIN : sum);
   assign cand    = cand_w[DB-1:0];
   assign db_dist = d_rdata[DW-1 -: DB];
   assign reach_a = reach_ff[ea_ff[VAW-1:0]];
   assign reach_b = reach_ff[eb_ff[VAW-1:0]];
   assign relax   = reach_a && (!reach_b || (cand < db_dist));

   assign seen_all = seen_ff | (src_ok_ff ? (VERTICES'(1) << src_ff[VAW-1:0]) : '0);
   assign ahead    = (seen_all >> v_ff) >> 1;
   assign more     = |ahead;

   always_comb begin
      state_in = state_ff;
      e_we     = 1'b0;
      e_waddr  = count_ff[EAW-1:0];
      e_wdata  = {req_bus.from_vertex, req_bus.to_vertex, w_sat[WEIGHT_BITS-1:0]};
      d_we     = 1'b0;
      d_waddr  = eb_ff[VAW-1:0];
      d_wdata  = {cand, ea_ff};
      d_raddr  = '0;
      load_vtx = 1'b0;
      load_neg = 1'b0;
      unique case (state_ff)
         ssp_pkg::S_IDLE: begin
            if (req_beat) begin
               if (req_bus.opcode == ssp_pkg::OP_ADD) begin
                  if (in_range) begin
                     e_we = room;
                     if (req_bus.two_way) begin
                        state_in = ssp_pkg::S_REV;
                     end
                  end
               end else begin
                  d_we     = src_in_range;
                  d_waddr  = req_bus.source_vertex[VAW-1:0];
                  d_wdata  = {{DB{1'b0}}, req_bus.source_vertex};
                  state_in = ssp_pkg::S_EDGE;
               end
            end
         end
         ssp_pkg::S_REV: begin
            e_we     = room;
            e_wdata  = {rev_a_ff, rev_b_ff, rev_w_ff};
            state_in = ssp_pkg::S_IDLE;
         end
         ssp_pkg::S_EDGE: begin
            if (k_ff == count_ff) begin
               if (!any_ff) begin
                  state_in = ssp_pkg::S_OUT_RD;
               end else if (pass_ff == PW'(VERTICES)) begin
                  state_in = ssp_pkg::S_NEG;
               end
            end else begin
               state_in = ssp_pkg::S_RDA;
            end
         end
         ssp_pkg::S_RDA: begin
            d_raddr  = e_rdata[EW-VB +: VAW];
            state_in = ssp_pkg::S_RDB;
         end
         ssp_pkg::S_RDB: begin
            d_raddr  = eb_ff[VAW-1:0];
            state_in = ssp_pkg::S_UPD;
         end
         ssp_pkg::S_UPD: begin
            d_we     = relax;
            state_in = ssp_pkg::S_EDGE;
         end
         ssp_pkg::S_NEG: begin
            if (out_free) begin
               load_neg = 1'b1;
               state_in = ssp_pkg::S_IDLE;
            end
         end
         ssp_pkg::S_OUT_RD: begin
            d_raddr = v_ff;
            if (seen_all[v_ff]) begin
               state_in = ssp_pkg::S_OUT_LD;
            end else if (v_ff == VAW'(VERTICES - 1)) begin
               state_in = ssp_pkg::S_IDLE;
            end
         end
         ssp_pkg::S_OUT_LD: begin
            d_raddr = v_ff;
            if (out_free) begin
               load_vtx = 1'b1;
               state_in = more ? ssp_pkg::S_OUT_RD : ssp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ssp_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // edge store bookkeeping and run control
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         seen_ff      <= '0;
         reach_ff     <= '0;
         src_ok_ff    <= 1'b0;
         k_ff         <= '0;
         pass_ff      <= '0;
         any_ff       <= 1'b0;
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (e_we) begin
            count_ff <= count_ff + CW'(1);
            if (state_ff == ssp_pkg::S_REV) begin
               seen_ff <= seen_ff | (VERTICES'(1) << rev_a_ff[VAW-1:0]) |
                          (VERTICES'(1) << rev_b_ff[VAW-1:0]);
            end else begin
               seen_ff <= seen_ff | (VERTICES'(1) << req_bus.from_vertex[VAW-1:0]) |
                          (VERTICES'(1) << req_bus.to_vertex[VAW-1:0]);
            end
         end
         if ((state_ff == ssp_pkg::S_REV ||
              (req_beat && req_bus.opcode == ssp_pkg::OP_ADD && in_range)) && !room) begin
            overflow_ff <= 1'b1;
         end
         if (req_beat && req_bus.opcode == ssp_pkg::OP_RUN) begin
            reach_ff  <= src_in_range ?
                         (VERTICES'(1) << req_bus.source_vertex[VAW-1:0]) : '0;
            src_ok_ff <= src_in_range;
            k_ff      <= '0;
            pass_ff   <= PW'(1);
            any_ff    <= 1'b0;
            v_ff      <= '0;
         end
         if (state_ff == ssp_pkg::S_EDGE && k_ff == count_ff && any_ff &&
             pass_ff != PW'(VERTICES)) begin
            pass_ff <= pass_ff + PW'(1);
            k_ff    <= '0;
            any_ff  <= 1'b0;
         end
         if (state_ff == ssp_pkg::S_UPD) begin
            k_ff <= k_ff + CW'(1);
            if (relax) begin
               reach_ff[eb_ff[VAW-1:0]] <= 1'b1;
               any_ff <= 1'b1;
            end
         end
         if ((state_ff == ssp_pkg::S_OUT_RD && !seen_all[v_ff]) || load_vtx) begin
            v_ff <= v_ff + VAW'(1);
         end
         if (load_vtx || load_neg) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rev_a_ff <= req_bus.to_vertex;
         rev_b_ff <= req_bus.from_vertex;
         rev_w_ff <= w_sat[WEIGHT_BITS-1:0];
         src_ff   <= req_bus.source_vertex;
      end
      if (state_ff == ssp_pkg::S_RDA) begin
         ea_ff <= e_rdata[EW-1 -: VB];
         eb_ff <= e_rdata[EW-VB-1 -: VB];
         ew_ff <= e_rdata[WEIGHT_BITS-1:0];
      end
      if (state_ff == ssp_pkg::S_RDB) begin
         da_ff <= d_rdata[DW-1 -: DB];
      end
      if (load_neg) begin
         o_vertex_ff <= src_ff;
         o_dist_ff   <= '0;
         o_reach_ff  <= 1'b0;
         o_parent_ff <= src_ff;
         o_neg_ff    <= 1'b1;
         o_drop_ff   <= overflow_ff;
         o_last_ff   <= 1'b1;
      end
      if (load_vtx) begin
         o_vertex_ff <= VB'(v_ff);
         o_reach_ff  <= reach_ff[v_ff];
         o_dist_ff   <= reach_ff[v_ff] ? db_dist : '0;
         o_parent_ff <= reach_ff[v_ff] ? d_rdata[VB-1:0] : VB'(v_ff);
         o_neg_ff    <= 1'b0;
         o_drop_ff   <= overflow_ff;
         o_last_ff   <= !more;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.vertex_index   = o_vertex_ff;
   assign rsp_bus.distance       = o_dist_ff;
   assign rsp_bus.reachable      = o_reach_ff;
   assign rsp_bus.parent_vertex  = o_parent_ff;
   assign rsp_bus.negative_cycle = o_neg_ff;
   assign rsp_bus.edges_dropped  = o_drop_ff;
   assign rsp_bus.last           = o_last_ff;

`ifndef SYNTH
   a_neg_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_neg_ff |-> o_last_ff)
      else $error("negative cycle beat without last");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_EDGES))
      else $error("edge count beyond store");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ssp_pkg::S_IDLE |-> pass_ff <= PW'(VERTICES))
      else $error("pass count beyond limit");

   a_dist_write: assert property (@(posedge clock) disable iff (reset)
      d_we |-> (state_ff == ssp_pkg::S_UPD ||
                (req_beat && req_bus.opcode == ssp_pkg::OP_RUN)))
      else $error("distance write outside relax or run start");
`endif

endmodule

// ===== hdl/ssp_ram.sv =====
module ssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
